// ===== src/bpt_pkg.sv =====
// Shared types and constants for the Bezier point and tangent core.
// No dependencies.
`timescale 1ns / 1ps
package bpt_pkg;
    localparam int MAX_POINTS_DEF  = 16;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int PT_W            = 17;
    localparam int CNT_W           = 5;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_EVAL = 2'd1,
        CMD_TAN  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [3:0]         point_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [16:0]        param_t;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               saturated;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_COPY, ST_LERP, ST_NSCALE, ST_NSQ, ST_NSQRT,
        ST_NDIV, ST_CLAMP, ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;   // capture input item, write store on load
        logic copy_step;   // copy one store entry into the work array
        logic lerp_step;   // one lerp of work[i], work[i+1]
        logic scale;       // normalize pre-scale
        logic sq_step;     // accumulate one square
        logic sqrt_step;   // one isqrt iteration
        logic div_step;    // one restoring division bit
        logic clamp;       // form output
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic       is_tan;
        logic       is_load;
        logic       is_none;
        logic       copy_done;
        logic       lerp_done;
        logic       zero_vec;
        logic       sq_done;
        logic       sqrt_done;
        logic       div_done;
    } sts_t;
endpackage

// ===== src/bpt_datapath.sv =====
// Datapath: control point store, work array, lerp unit, normalize units.
// Depends on bpt_pkg.
`timescale 1ns / 1ps
module bpt_datapath import bpt_pkg::*; #(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  ctl_t      ctl,
    input  in_item_t  in_item,
    input  logic [CNT_W-1:0] point_count,
    output sts_t      sts,
    output out_item_t res
);
    localparam int IW = $clog2(MAX_POINTS);
    localparam int WW = COORD_WIDTH + 2;    // work word: room for differences
    localparam int CW = IW + 1;

    // store memories
    logic signed [COORD_WIDTH-1:0] mem_x [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] mem_y [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] mem_z [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] rd_x_reg, rd_y_reg, rd_z_reg;

    logic signed [WW-1:0] wk [MAX_POINTS][3];
    logic [1:0]  cmd_reg;
    logic [16:0] t_reg;
    logic [CW-1:0] n_reg, rd_idx_reg, cp_idx_reg, i_reg, r_reg;
    logic          rd_vld_reg;

    // normalize state
    logic signed [31:0] c_reg [3];
    logic [63:0] sum_reg, rem_reg, res_reg, bit_reg;
    logic [1:0]  k_reg;
    logic [48:0] num_reg;
    logic [48:0] q_reg;
    logic [31:0] len_reg;
    logic [5:0]  dcnt_reg;
    logic signed [49:0] fin_reg [3];

    function automatic logic signed [COORD_WIDTH-1:0] clampc(logic signed [31:0] v);
        logic signed [63:0] w;
        logic signed [63:0] mx, mn;
        w  = 64'(v);
        mx = (64'sd1 <<< (COORD_WIDTH-1)) - 64'sd1;
        mn = -(64'sd1 <<< (COORD_WIDTH-1));
        if (w > mx) w = mx;
        if (w < mn) w = mn;
        return w[COORD_WIDTH-1:0];
    endfunction

    // effective point count
    logic [CW-1:0] n_eff;
    always_comb begin
        if (point_count < CNT_W'(2)) n_eff = CW'(2);
        else if (32'(point_count) > MAX_POINTS) n_eff = CW'(MAX_POINTS);
        else n_eff = CW'(point_count);
    end

    // store write and registered read
    always_ff @(posedge aclk) begin
        if (ctl.load_item && in_item.command == CMD_LOAD
            && 32'(in_item.point_index) < MAX_POINTS) begin
            mem_x[in_item.point_index[IW-1:0]] <= clampc(in_item.coord_x);
            mem_y[in_item.point_index[IW-1:0]] <= clampc(in_item.coord_y);
            mem_z[in_item.point_index[IW-1:0]] <= clampc(in_item.coord_z);
        end
        rd_x_reg <= mem_x[rd_idx_reg[IW-1:0]];
        rd_y_reg <= mem_y[rd_idx_reg[IW-1:0]];
        rd_z_reg <= mem_z[rd_idx_reg[IW-1:0]];
    end

    // shared lerp on three axes
    logic signed [WW-1:0] la [3], lb [3], lr [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [WW:0] d;
            logic signed [WW-16:0] dh;
            logic [15:0] dl;
            logic [32:0] fr;
            logic signed [WW+18:0] p;
            la[k] = wk[i_reg[IW-1:0]][k];
            lb[k] = wk[(i_reg[IW-1:0] + IW'(1))][k];
            d  = (WW+1)'(lb[k]) - (WW+1)'(la[k]);
            dh = d[WW:16];
            dl = d[15:0];
            fr = (33'(dl) * 33'(t_reg) + 33'd32768) >> 16;
            p  = (WW+19)'(dh) * $signed({1'b0, t_reg}) + (WW+19)'(la[k])
                 + (WW+19)'($signed({1'b0, fr}));
            lr[k] = p[WW-1:0];
        end
    end

    // magnitude helpers
    function automatic logic [WW-1:0] mag(logic signed [WW-1:0] v);
        return v[WW-1] ? WW'(-v) : WW'(v);
    endfunction
    logic [WW-1:0] mmax;
    logic [6:0]    blen;
    always_comb begin
        mmax = mag(wk[0][0]);
        if (mag(wk[0][1]) > mmax) mmax = mag(wk[0][1]);
        if (mag(wk[0][2]) > mmax) mmax = mag(wk[0][2]);
        blen = 7'd0;
        for (int b = 0; b < WW; b++) if (mmax[b]) blen = 7'(b + 1);
    end

    logic [31:0] cmag [3];
    always_comb for (int k = 0; k < 3; k++)
        cmag[k] = c_reg[k][31] ? 32'(-c_reg[k]) : 32'(c_reg[k]);

    logic [63:0] trial;
    assign trial = res_reg + bit_reg;
    // isqrt partial root after this step
    logic [63:0] res_new;
    assign res_new = (rem_reg >= trial) ? (res_reg >> 1) + bit_reg : res_reg >> 1;
    logic [48:0] num_sh;
    assign num_sh = {num_reg[47:0], q_reg[48]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            cmd_reg    <= CMD_NONE;
        end else begin
            if (ctl.load_item) begin
                cmd_reg    <= in_item.command;
                t_reg      <= (in_item.param_t > 17'd65536) ? 17'd65536 : in_item.param_t;
                n_reg      <= n_eff;
                rd_idx_reg <= '0;
                cp_idx_reg <= '0;
                rd_vld_reg <= 1'b0;
            end
            if (ctl.copy_step) begin
                // issue reads ahead, write the registered data behind
                rd_idx_reg <= (rd_idx_reg == n_reg - CW'(1)) ? rd_idx_reg
                                                             : rd_idx_reg + CW'(1);
                rd_vld_reg <= 1'b1;
                if (rd_vld_reg) begin
                    logic signed [WW-1:0] px, py, pz;
                    px = WW'(rd_x_reg); py = WW'(rd_y_reg); pz = WW'(rd_z_reg);
                    wk[cp_idx_reg[IW-1:0]][0] <= px;
                    wk[cp_idx_reg[IW-1:0]][1] <= py;
                    wk[cp_idx_reg[IW-1:0]][2] <= pz;
                    if (cmd_reg == CMD_TAN && cp_idx_reg != '0) begin
                        wk[cp_idx_reg[IW-1:0] - IW'(1)][0] <=
                            px - wk[cp_idx_reg[IW-1:0] - IW'(1)][0];
                        wk[cp_idx_reg[IW-1:0] - IW'(1)][1] <=
                            py - wk[cp_idx_reg[IW-1:0] - IW'(1)][1];
                        wk[cp_idx_reg[IW-1:0] - IW'(1)][2] <=
                            pz - wk[cp_idx_reg[IW-1:0] - IW'(1)][2];
                    end
                    cp_idx_reg <= cp_idx_reg + CW'(1);
                end
                i_reg <= '0;
                r_reg <= (cmd_reg == CMD_TAN) ? CW'(2) : CW'(1);
            end
            if (ctl.lerp_step) begin
                for (int k = 0; k < 3; k++) wk[i_reg[IW-1:0]][k] <= lr[k];
                if (i_reg + r_reg + CW'(1) >= n_reg) begin
                    i_reg <= '0;
                    r_reg <= r_reg + CW'(1);
                end else begin
                    i_reg <= i_reg + CW'(1);
                end
            end
            if (ctl.scale) begin
                for (int k = 0; k < 3; k++) begin
                    logic signed [WW+31:0] e;
                    e = (WW+32)'(wk[0][k]);
                    if (blen > 7'd31) c_reg[k] <= 32'(e >>> (blen - 7'd31));
                    else              c_reg[k] <= 32'(e <<< (7'd31 - blen));
                end
                sum_reg <= '0;
                k_reg   <= '0;
            end
            if (ctl.sq_step) begin
                sum_reg <= sum_reg + 64'(cmag[k_reg]) * 64'(cmag[k_reg]);
                k_reg   <= k_reg + 2'd1;
                rem_reg <= sum_reg + 64'(cmag[k_reg]) * 64'(cmag[k_reg]);
                res_reg <= '0;
                bit_reg <= 64'd1 << 62;
            end
            if (ctl.sqrt_step) begin
                if (rem_reg >= trial) rem_reg <= rem_reg - trial;
                res_reg <= res_new;
                bit_reg <= bit_reg >> 2;
                if (bit_reg == 64'd1) begin
                    k_reg <= '0;
                end
                len_reg <= 32'(res_new);
                num_reg <= '0;
                q_reg   <= 49'({cmag[0], 16'd0}) + 49'(res_new >> 1);
                dcnt_reg <= '0;
            end
            if (ctl.div_step) begin
                // restoring division, one quotient bit per cycle
                logic        qb;
                logic [48:0] q_new;
                qb    = (num_sh >= 49'(len_reg));
                q_new = {q_reg[47:0], qb};
                if (dcnt_reg == 6'd48) begin
                    fin_reg[k_reg] <= c_reg[k_reg][31] ? -50'(q_new) : 50'(q_new);
                    dcnt_reg <= '0;
                    num_reg  <= '0;
                    if (k_reg != 2'd2)
                        q_reg <= 49'({cmag[k_reg + 2'd1], 16'd0}) + 49'(len_reg >> 1);
                    k_reg <= k_reg + 2'd1;
                end else begin
                    num_reg  <= qb ? num_sh - 49'(len_reg) : num_sh;
                    q_reg    <= q_new;
                    dcnt_reg <= dcnt_reg + 6'd1;
                end
            end
            if (ctl.clamp) begin
                logic s;
                logic signed [WW+17:0] v [3];
                s = 1'b0;
                for (int k = 0; k < 3; k++) begin
                    if (cmd_reg == CMD_TAN && !sts.zero_vec) v[k] = (WW+18)'(fin_reg[k]);
                    else if (cmd_reg == CMD_TAN) v[k] = '0;
                    else v[k] = (WW+18)'(wk[0][k]);
                    if (v[k] > (WW+18)'(32'sh7fffffff)) begin
                        v[k] = (WW+18)'(32'sh7fffffff); s = 1'b1;
                    end
                    if (v[k] < -(WW+18)'(33'sh80000000)) begin
                        v[k] = -(WW+18)'(33'sh80000000); s = 1'b1;
                    end
                end
                res.out_x     <= v[0][31:0];
                res.out_y     <= v[1][31:0];
                res.out_z     <= v[2][31:0];
                res.saturated <= s;
            end
        end
    end

    // status to controller
    always_comb begin
        sts.is_tan    = (in_item.command == CMD_TAN);
        sts.is_load   = (in_item.command == CMD_LOAD);
        sts.is_none   = (in_item.command == CMD_NONE);
        sts.copy_done = rd_vld_reg && (cp_idx_reg == n_reg - CW'(1));
        sts.lerp_done = (r_reg >= n_reg);
        sts.zero_vec  = (mmax == '0);
        sts.sq_done   = (k_reg == 2'd2);
        sts.sqrt_done = (bit_reg == 64'd1);
        sts.div_done  = (k_reg == 2'd2) && (dcnt_reg == 6'd48);
    end
endmodule

// ===== src/bpt_ctrl.sv =====
// Controller state machine sequencing copy, lerp and normalize steps.
// Depends on bpt_pkg.
`timescale 1ns / 1ps
module bpt_ctrl import bpt_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    input  logic is_tan_q,
    output ctl_t ctl
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) begin
                if (sts.is_load || sts.is_none) state_next = ST_IDLE;
                else state_next = ST_COPY;
            end
            ST_COPY:   if (sts.copy_done) state_next = ST_LERP;
            ST_LERP:   if (sts.lerp_done) state_next = is_tan_q ? ST_NSCALE : ST_CLAMP;
            ST_NSCALE: state_next = sts.zero_vec ? ST_CLAMP : ST_NSQ;
            ST_NSQ:    if (sts.sq_done) state_next = ST_NSQRT;
            ST_NSQRT:  if (sts.sqrt_done) state_next = ST_NDIV;
            ST_NDIV:   if (sts.div_done) state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_OUT;
            ST_OUT:    if (out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctl = '0;
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        unique case (state_reg)
            ST_IDLE:   ctl.load_item = in_valid;
            ST_COPY:   ctl.copy_step = 1'b1;
            ST_LERP:   ctl.lerp_step = !sts.lerp_done;
            ST_NSCALE: ctl.scale     = 1'b1;
            ST_NSQ:    ctl.sq_step   = 1'b1;
            ST_NSQRT:  ctl.sqrt_step = 1'b1;
            ST_NDIV:   ctl.div_step  = 1'b1;
            ST_CLAMP:  ctl.clamp     = 1'b1;
            default:   ctl = '0;
        endcase
    end

    ap_out_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> !in_ready) else $error("accept while result pending");
    ap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    ap_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.clamp |=> out_valid) else $error("no result after clamp");
endmodule

// ===== src/bezier_point_and_tangent_core.sv =====
// Top level of the Bezier point and tangent core.
// Depends on bpt_pkg, bpt_ctrl, bpt_datapath.
//
//  channel | ports              | payload
//  input   | s_valid / s_ready  | in_item_t
//  result  | m_valid / m_ready  | out_item_t
//  config  | cfg_valid/cfg_ready| point_count
//
// Load: the point is written into the store on acceptance and no result follows.
// Evaluate: the n points are copied into the work array, then lerped one at a time by the single shared lerp per axis.
// Tangent: copy with differences and lerps as for evaluate, then 3 square steps, 32 isqrt steps and
// 3 x 49 division steps in the one bit-serial divider unless the vector is zero.
// Reset clears control state and sets point_count to 2. A stalled result
// holds the block until it is taken.
`timescale 1ns / 1ps
module bezier_point_and_tangent_core import bpt_pkg::*; #(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);
    logic [CNT_W-1:0] point_count_reg;
    logic is_tan_reg;
    ctl_t ctl;
    sts_t sts;

    assign cfg_ready = 1'b1;
    // hold configuration and command kind
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= CNT_W'(2);
            is_tan_reg      <= 1'b0;
        end else begin
            if (cfg_valid) point_count_reg <= cfg_data;
            if (ctl.load_item) is_tan_reg <= sts.is_tan;
        end
    end

    bpt_ctrl u_ctrl (
        .aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready),
        .out_valid(m_valid), .out_ready(m_ready), .sts, .is_tan_q(is_tan_reg), .ctl
    );

    bpt_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
        .aclk, .aresetn, .ctl, .in_item(s_data), .point_count(point_count_reg),
        .sts, .res(m_data)
    );
endmodule
